FILE: hdl/pcx_rle_palette_decoder_macros.svh
// Assertion macros for the PCX RLE palette decoder.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef PCX_RLE_PALETTE_DECODER_MACROS_SVH
`define PCX_RLE_PALETTE_DECODER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PCX_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PCX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/pcx_pkg.sv
// Shared types and constants for the PCX RLE palette decoder.
// No dependencies.
package pcx_pkg;

    localparam int MAX_DIMENSION   = 4096;
    localparam int PALETTE_ENTRIES = 256;
    localparam int CFG_DIM_W       = 13;   // width of the geometry registers
    localparam int RUN_W           = 6;    // run length field
    localparam int PIX_W           = 17;   // screen coordinate width
    localparam int CFG_DATA_W      = 16;
    localparam int CFG_IDX_W       = 3;

    localparam logic [7:0] RUN_MARK   = 8'd192;
    localparam logic [7:0] MASK_ALPHA = 8'hAA;

    // request opcodes
    localparam logic OP_DATA    = 1'b0;
    localparam logic OP_PALETTE = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_COLOR   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_ENABLE  = 3'd5;

    typedef struct packed {
        logic        operation;
        logic [7:0]  data_byte;
        logic [7:0]  palette_index;
        logic [31:0] palette_color;
    } in_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_x;
        logic [PIX_W-1:0] pixel_y;
        logic [7:0]       blue;
        logic [7:0]       green;
        logic [7:0]       red;
        logic [7:0]       alpha;
        logic             masked;
        logic             last_of_run;
        logic             image_done;
        logic             overrun;
    } out_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;   // input request taken this cycle
        logic mul;      // register (rows left) * width
        logic check;    // clip the run against pixels left
        logic emit;     // push one pixel into the output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic run_start;   // accepted request produces pixels
        logic out_free;    // output register can take a pixel
        logic last_pixel;  // one pixel left in the current run
    } sts_t;

endpackage

FILE: hdl/pcx_ctrl.sv
// Sequencer for the PCX RLE palette decoder.
// Depends on pcx_pkg (cmd_t, sts_t).
module pcx_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  pcx_pkg::sts_t sts,
    output pcx_pkg::cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_CHECK,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid && sts.run_start)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.emit = sts.out_free;
                if (sts.out_free && sts.last_pixel)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hdl/pcx_dpath.sv
// Datapath of the PCX RLE palette decoder: registers, run state,
// palette memory, position counters, clip check and output register.
// Depends on pcx_pkg.
module pcx_dpath #(
    parameter int MAX_DIMENSION = pcx_pkg::MAX_DIMENSION
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [pcx_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pcx_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  pcx_pkg::in_t                       in_data,
    input  pcx_pkg::cmd_t                      cmd,
    output pcx_pkg::sts_t                      sts,
    output logic                               out_valid,
    input  logic                               out_stall,
    output pcx_pkg::out_t                      out_data
);

    localparam int DIM_W = $clog2(MAX_DIMENSION + 1);
    localparam int CNT_W = $clog2(MAX_DIMENSION);
    localparam int CLW   = (DIM_W > pcx_pkg::CFG_DIM_W) ? DIM_W : pcx_pkg::CFG_DIM_W;
    localparam int PW    = 2 * DIM_W;

    // configuration
    logic [pcx_pkg::CFG_DIM_W-1:0] width_reg;
    logic [pcx_pkg::CFG_DIM_W-1:0] height_reg;
    logic [15:0]                   origin_x_reg;
    logic [15:0]                   origin_y_reg;
    logic [7:0]                    mask_color_reg;
    logic                          mask_enable_reg;

    // decoder state
    logic                       run_pending_reg;
    logic [pcx_pkg::RUN_W-1:0]  run_length_reg;
    logic [CNT_W-1:0]           col_reg;
    logic [CNT_W-1:0]           row_reg;
    logic [CNT_W-1:0]           col_next;
    logic [CNT_W-1:0]           row_next;

    // per-run working registers
    logic [7:0]                 idx_reg;
    logic [pcx_pkg::RUN_W-1:0]  count_reg;
    logic [pcx_pkg::RUN_W-1:0]  count_next;
    logic [31:0]                color_reg;
    logic [PW-1:0]              prod_reg;
    logic                       clip_reg;

    logic                       out_valid_reg;
    pcx_pkg::out_t              out_reg;
    pcx_pkg::out_t              out_next;

    logic [31:0] palette_mem [pcx_pkg::PALETTE_ENTRIES];

    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;
    logic             is_data;
    logic             is_header;
    logic             start_run;
    logic             pos_bad;
    logic [DIM_W-1:0] col_inc;
    logic [DIM_W-1:0] row_inc;
    logic             wrap;
    logic             done;
    logic [PW-1:0]    remaining;
    logic             clipped;
    logic             is_masked;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [pcx_pkg::CFG_DIM_W-1:0] v);
        logic [CLW-1:0] ve;
        ve = CLW'(v);
        if (v == '0)
            return DIM_W'(1);
        else if (ve > CLW'(MAX_DIMENSION))
            return DIM_W'(MAX_DIMENSION);
        else
            return DIM_W'(ve);
    endfunction

    assign w_eff = clamp_dim(width_reg);
    assign h_eff = clamp_dim(height_reg);

    // request decode
    assign is_data   = (in_data.operation == pcx_pkg::OP_DATA);
    assign is_header = !run_pending_reg && (in_data.data_byte >= pcx_pkg::RUN_MARK);
    assign start_run = is_data && (run_pending_reg ? (run_length_reg != '0) : !is_header);
    assign pos_bad   = (DIM_W'(col_reg) >= w_eff) || (DIM_W'(row_reg) >= h_eff);

    // position advance
    assign col_inc  = DIM_W'(col_reg) + DIM_W'(1);
    assign row_inc  = DIM_W'(row_reg) + DIM_W'(1);
    assign wrap     = (col_inc >= w_eff);
    assign done     = wrap && (row_inc >= h_eff);
    assign col_next = wrap ? '0 : CNT_W'(col_inc);
    assign row_next = done ? '0 : (wrap ? CNT_W'(row_inc) : row_reg);

    // pixels left in the image = (rows left) * width - column
    assign remaining  = prod_reg - PW'(col_reg);
    assign clipped    = PW'(count_reg) > remaining;
    assign count_next = clipped ? remaining[pcx_pkg::RUN_W-1:0] : count_reg;
    assign is_masked  = mask_enable_reg && (idx_reg == mask_color_reg);

    always_comb
    begin
        out_next.pixel_x     = pcx_pkg::PIX_W'(origin_x_reg) + pcx_pkg::PIX_W'(col_reg);
        out_next.pixel_y     = pcx_pkg::PIX_W'(origin_y_reg) + pcx_pkg::PIX_W'(row_reg);
        out_next.blue        = color_reg[7:0];
        out_next.green       = color_reg[15:8];
        out_next.red         = color_reg[23:16];
        out_next.alpha       = is_masked ? pcx_pkg::MASK_ALPHA : color_reg[31:24];
        out_next.masked      = is_masked;
        out_next.last_of_run = (count_reg == pcx_pkg::RUN_W'(1));
        out_next.image_done  = done;
        out_next.overrun     = clip_reg;
    end

    assign sts.run_start  = start_run;
    assign sts.out_free   = !out_valid_reg || !out_stall;
    assign sts.last_pixel = (count_reg == pcx_pkg::RUN_W'(1));

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // palette: one write port, registered read on every accepted request
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            if (!is_data)
            begin
                palette_mem[in_data.palette_index] <= in_data.palette_color;
            end
            color_reg <= palette_mem[in_data.data_byte];
        end
    end

    // working registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            idx_reg   <= in_data.data_byte;
            count_reg <= run_pending_reg ? run_length_reg : pcx_pkg::RUN_W'(1);
        end
        else if (cmd.check)
        begin
            count_reg <= count_next;
        end
        else if (cmd.emit)
        begin
            count_reg <= count_reg - pcx_pkg::RUN_W'(1);
        end
        if (cmd.mul)
        begin
            prod_reg <= PW'(h_eff - DIM_W'(row_reg)) * PW'(w_eff);
        end
        if (cmd.check)
        begin
            clip_reg <= clipped;
        end
        if (cmd.emit)
        begin
            out_reg <= out_next;
        end
    end

    // configuration and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg       <= pcx_pkg::CFG_DIM_W'(1);
            height_reg      <= pcx_pkg::CFG_DIM_W'(1);
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            mask_color_reg  <= '0;
            mask_enable_reg <= 1'b0;
            run_pending_reg <= 1'b0;
            run_length_reg  <= '0;
            col_reg         <= '0;
            row_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    pcx_pkg::REG_IMAGE_WIDTH:  width_reg       <= cfg_data[pcx_pkg::CFG_DIM_W-1:0];
                    pcx_pkg::REG_IMAGE_HEIGHT: height_reg      <= cfg_data[pcx_pkg::CFG_DIM_W-1:0];
                    pcx_pkg::REG_ORIGIN_X:     origin_x_reg    <= cfg_data;
                    pcx_pkg::REG_ORIGIN_Y:     origin_y_reg    <= cfg_data;
                    pcx_pkg::REG_MASK_COLOR:   mask_color_reg  <= cfg_data[7:0];
                    pcx_pkg::REG_MASK_ENABLE:  mask_enable_reg <= cfg_data[0];
                    default: ;
                endcase
            end

            if (cmd.accept && is_data)
            begin
                if (run_pending_reg)
                begin
                    run_pending_reg <= 1'b0;
                end
                else if (is_header)
                begin
                    run_pending_reg <= 1'b1;
                    run_length_reg  <= pcx_pkg::RUN_W'(in_data.data_byte - pcx_pkg::RUN_MARK);
                end
            end

            // geometry write restarts the scan
            priority if (cfg_we && (cfg_index == pcx_pkg::REG_IMAGE_WIDTH ||
                                    cfg_index == pcx_pkg::REG_IMAGE_HEIGHT))
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (cmd.accept && start_run && pos_bad)
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (cmd.emit)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            else
            begin
                col_reg <= col_reg;
                row_reg <= row_reg;
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

FILE: hdl/pcx_rle_palette_decoder.sv
// Top level of the PCX RLE palette decoder.
// Depends on pcx_pkg, pcx_ctrl, pcx_dpath and pcx_rle_palette_decoder_macros.svh.
//
// Usage:
//  - Input channel (in_valid / in_stall / in_data): one request per byte of
//    the compressed stream (operation = data) or one palette entry write
//    (operation = palette). Palette writes and run headers give no pixels.
//  - Output channel (out_valid / out_stall / out_data): the pixels of each request,
//    with screen position, palette color, mask flag and run/image markers.
//  - Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): always
//    ready; write only while the decoder is idle. Writing width or height
//    restarts the scan at the top left corner.
//  - Sequence: a request that yields no pixel leaves the input open. A
//    request that yields N pixels goes through palette read, multiply for
//    pixels left in the image and clip check, then the emit loop gives one
//    pixel a cycle while the receiver does not stall. Input is stalled for
//    the whole run.
//  - Receiver stall holds the output register; the emit loop waits on it.
//  - Reset clears registers and counters; palette contents are undefined
//    until written. No clearing pass.
`include "pcx_rle_palette_decoder_macros.svh"

module pcx_rle_palette_decoder #(
    parameter int MAX_DIMENSION = pcx_pkg::MAX_DIMENSION
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // input requests
    input  logic                           in_valid,
    output logic                           in_stall,
    input  pcx_pkg::in_t                   in_data,
    // pixel results
    output logic                           out_valid,
    input  logic                           out_stall,
    output pcx_pkg::out_t                  out_data,
    // register writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pcx_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pcx_pkg::CFG_DATA_W-1:0] cfg_data
);

    pcx_pkg::cmd_t cmd;
    pcx_pkg::sts_t sts;
    logic          cfg_we;

    // register file never back-pressures
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    pcx_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    pcx_dpath #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // a pixel is only pushed when the output register has room
    `PCX_ASSERT_NOW(a_emit_room, cmd.emit, sts.out_free, "pixel pushed into full output")
    // no new request is taken while a run is still being emitted
    `PCX_ASSERT_NOW(a_no_accept_in_run, cmd.emit, in_stall, "request taken during run")
    // a request that starts a run closes the input on the next cycle
    `PCX_ASSERT_NEXT(a_run_stalls, cmd.accept && sts.run_start, in_stall, "run did not stall input")

endmodule
